// ===== hdl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Character codes, the opcode, the register map, sequencer states and the
// result bundle passed from the control unit to the top level.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS_DEFAULT  = 80;
   localparam int ROWS_DEFAULT     = 25;
   localparam int TAB_STEP_DEFAULT = 8;

   // opcodes
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // character codes with a special meaning
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_RETURN  = 8'h0D;
   localparam logic [7:0] CHAR_BLANK   = 8'h20;

   localparam logic [7:0] RESET_ATTR = 8'h07;

   // register map (word index from paddr[2])
   localparam int          CSR_ADDR_W          = 3;
   localparam logic        CSR_IDX_CLEAR_ATTR  = 1'b0;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_SPAN,
      ST_COPY,
      ST_FLUSH,
      ST_BOTTOM,
      ST_POST
   } state_type;

   typedef struct packed {
      logic [15:0] cell_data;
      logic [6:0]  cursor_column;
      logic [4:0]  cursor_row;
      logic [10:0] cursor_position;
      logic        scrolled;
   } rsp_type;

endpackage

// ===== hdl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// Keeps a screen of character/attribute cells and a cursor; put beats print
// or handle control characters, read beats return one cell.
// ----------------------------------------------------------------------------
//   channel  role    ports
//   req_     in      valid/ready, opcode, char_code, color, read_address
//   rsp_     out     valid/ready, cell_data, cursor_column/row/position,
//                    scrolled
//   csr_     config  apb-style, clear_attribute at byte address 0
//
// one beat at a time: printable and return go straight to the result, a read
// in range passes the read state, newline/tab blank their span; a scroll adds
// a row copy and a bottom-row blanking, all on the single sweep counter and
// the one memory write port.
// after reset a pass over all COLUMNS*ROWS cells (2000 by default) fills the
// store with blanks before req_ready rises; csr writes are taken as ever.
// the result register lets the next beat enter while a result waits on rsp_.
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int COLUMNS  = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS     = tcw_pkg::ROWS_DEFAULT,
   parameter int TAB_STEP = tcw_pkg::TAB_STEP_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_opcode,
   input  logic [7:0]                      req_char_code,
   input  logic [7:0]                      req_color,
   input  logic [10:0]                     req_read_address,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [15:0]                     rsp_cell_data,
   output logic [6:0]                      rsp_cursor_column,
   output logic [4:0]                      rsp_cursor_row,
   output logic [10:0]                     rsp_cursor_position,
   output logic                            rsp_scrolled,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int AW         = $clog2(CELL_COUNT);

   logic [7:0]        attr_ff, attr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type  rsp_ff, rsp_in;

   tcw_pkg::rsp_type  res;
   logic              res_valid, res_take;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [15:0]       mem_wdata, mem_rdata;
   logic              csr_hit;

   // configuration register
   always_comb begin
      csr_hit    = (csr_paddr[2] == tcw_pkg::CSR_IDX_CLEAR_ATTR);
      csr_pready = 1'b1;
      attr_in    = attr_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         attr_in = csr_pwdata[7:0];
      end
      csr_prdata = csr_hit ? {24'h000000, attr_ff} : 32'h00000000;
   end

   // result register
   always_comb begin
      res_take     = !rsp_valid_ff || rsp_ready;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (res_valid && res_take) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= tcw_pkg::RESET_ATTR;
         rsp_valid_ff <= 1'b0;
      end else begin
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_data       = rsp_ff.cell_data;
   assign rsp_cursor_column   = rsp_ff.cursor_column;
   assign rsp_cursor_row      = rsp_ff.cursor_row;
   assign rsp_cursor_position = rsp_ff.cursor_position;
   assign rsp_scrolled        = rsp_ff.scrolled;

   tcw_ctrl #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STEP (TAB_STEP),
      .AW       (AW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_char_code    (req_char_code),
      .req_color        (req_color),
      .req_read_address (req_read_address),
      .clear_attr       (attr_ff),
      .res_valid        (res_valid),
      .res_take         (res_take),
      .res              (res),
      .mem_we           (mem_we),
      .mem_waddr        (mem_waddr),
      .mem_wdata        (mem_wdata),
      .mem_raddr        (mem_raddr),
      .mem_rdata        (mem_rdata)
   );

   tcw_store #(
      .DEPTH (CELL_COUNT),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule

// ===== hdl/tcw_store.sv =====
// ----------------------------------------------------------------------------
// tcw_store: screen cell memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_store #(
   parameter int DEPTH = tcw_pkg::COLUMNS_DEFAULT * tcw_pkg::ROWS_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);

   logic [15:0] mem_ff [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl: cursor logic and sweep sequencer
// Decodes each item, moves the cursor and drives one address sweep unit
// that clears spans, copies rows up on a scroll and blanks the bottom row.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
   parameter int COLUMNS  = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS     = tcw_pkg::ROWS_DEFAULT,
   parameter int TAB_STEP = tcw_pkg::TAB_STEP_DEFAULT,
   parameter int AW       = $clog2(COLUMNS * ROWS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_opcode,
   input  logic [7:0]        req_char_code,
   input  logic [7:0]        req_color,
   input  logic [10:0]       req_read_address,
   input  logic [7:0]        clear_attr,
   output logic              res_valid,
   input  logic              res_take,
   output tcw_pkg::rsp_type  res,
   output logic              mem_we,
   output logic [AW-1:0]     mem_waddr,
   output logic [15:0]       mem_wdata,
   output logic [AW-1:0]     mem_raddr,
   input  logic [15:0]       mem_rdata
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int CLW        = $clog2(COLUMNS);
   localparam int RW         = $clog2(ROWS);
   localparam int SW         = $clog2(COLUMNS + TAB_STEP + 1);

   localparam logic [AW-1:0] ADDR_LAST  = AW'(CELL_COUNT - 1);
   localparam logic [AW-1:0] ADDR_COLS  = AW'(COLUMNS);
   localparam logic [AW-1:0] ADDR_BOT   = AW'(CELL_COUNT - COLUMNS);
   localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);
   localparam logic [SW-1:0] SUM_COLS   = SW'(COLUMNS);

   tcw_pkg::state_type state_ff, state_in;

   logic [CLW-1:0] col_ff,      col_in;
   logic [RW-1:0]  row_ff,      row_in;
   logic [AW-1:0]  sweep_ff,    sweep_in;
   logic [AW-1:0]  last_ff,     last_in;
   logic           scroll_ff,   scroll_in;
   logic [15:0]    cell_ff,     cell_in;
   logic           copy_wr_ff,  copy_wr_in;
   logic [AW-1:0]  copy_wa_ff,  copy_wa_in;

   logic           accept;
   logic           is_read, read_ok, is_nl, is_cr, is_tab;
   logic [AW-1:0]  base, cur;
   logic [SW-1:0]  tab_sum, tab_end, inc_sum;
   logic           wrap;
   logic           sweep_end;

   // decode of the item at the input
   always_comb begin
      accept    = req_valid && (state_ff == tcw_pkg::ST_IDLE);
      is_read   = (req_opcode == tcw_pkg::OP_READ);
      read_ok   = 32'(req_read_address) < 32'(CELL_COUNT);
      is_nl     = (req_char_code == tcw_pkg::CHAR_NEWLINE);
      is_cr     = (req_char_code == tcw_pkg::CHAR_RETURN);
      is_tab    = (req_char_code == tcw_pkg::CHAR_TAB);
      base      = AW'(row_ff * COLUMNS);
      cur       = base + AW'(col_ff);
      tab_sum   = SW'(col_ff) + SW'(TAB_STEP);
      tab_end   = (tab_sum > SUM_COLS) ? SUM_COLS : tab_sum;
      inc_sum   = SW'(col_ff) + SW'(1);
      sweep_end = (sweep_ff == last_ff);
      if (is_nl) begin
         wrap = 1'b1;
      end else if (is_cr) begin
         wrap = 1'b0;
      end else if (is_tab) begin
         wrap = (tab_sum >= SUM_COLS);
      end else begin
         wrap = (inc_sum >= SUM_COLS);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcw_pkg::ST_INIT: begin
            if (sweep_end) state_in = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               if (is_read) begin
                  state_in = read_ok ? tcw_pkg::ST_READ : tcw_pkg::ST_POST;
               end else if (is_nl || is_tab) begin
                  state_in = tcw_pkg::ST_SPAN;
               end else if (is_cr) begin
                  state_in = tcw_pkg::ST_POST;
               end else begin
                  state_in = (wrap && row_ff == ROW_LAST) ? tcw_pkg::ST_COPY
                                                          : tcw_pkg::ST_POST;
               end
            end
         end
         tcw_pkg::ST_READ: state_in = tcw_pkg::ST_POST;
         tcw_pkg::ST_SPAN: begin
            if (sweep_end) state_in = scroll_ff ? tcw_pkg::ST_COPY : tcw_pkg::ST_POST;
         end
         tcw_pkg::ST_COPY: begin
            if (sweep_end) state_in = tcw_pkg::ST_FLUSH;
         end
         tcw_pkg::ST_FLUSH: state_in = tcw_pkg::ST_BOTTOM;
         tcw_pkg::ST_BOTTOM: begin
            if (sweep_end) state_in = tcw_pkg::ST_POST;
         end
         tcw_pkg::ST_POST: begin
            if (res_take) state_in = tcw_pkg::ST_IDLE;
         end
         default: state_in = tcw_pkg::ST_INIT;
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      sweep_in   = sweep_ff + AW'(1);
      last_in    = last_ff;
      scroll_in  = scroll_ff;
      cell_in    = cell_ff;
      copy_wr_in = (state_ff == tcw_pkg::ST_COPY);
      copy_wa_in = sweep_ff - ADDR_COLS;
      req_ready  = 1'b0;
      res_valid  = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = sweep_ff;
      mem_wdata  = {clear_attr, tcw_pkg::CHAR_BLANK};
      mem_raddr  = sweep_ff;
      case (state_ff)
         tcw_pkg::ST_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::CHAR_BLANK};
         end
         tcw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            mem_raddr = AW'(req_read_address);
            if (accept) begin
               cell_in   = 16'h0000;
               scroll_in = 1'b0;
               sweep_in  = (is_nl || is_tab) ? cur : ADDR_COLS;
               last_in   = is_nl ? base + AW'(COLUMNS - 1)
                                 : base + AW'(tab_end) - AW'(1);
               if (!is_read) begin
                  if (is_cr) begin
                     col_in = '0;
                  end else if (wrap) begin
                     col_in = '0;
                     if (row_ff == ROW_LAST) begin
                        scroll_in = 1'b1;
                     end else begin
                        row_in = row_ff + RW'(1);
                     end
                  end else if (is_tab) begin
                     col_in = CLW'(tab_sum);
                  end else begin
                     col_in = CLW'(inc_sum);
                  end
                  if (!is_nl && !is_cr && !is_tab) begin
                     mem_we    = 1'b1;
                     mem_waddr = cur;
                     mem_wdata = {req_color, req_char_code};
                  end
               end
            end
         end
         tcw_pkg::ST_READ: begin
            cell_in = mem_rdata;
         end
         tcw_pkg::ST_SPAN: begin
            mem_we = 1'b1;
            if (sweep_end) begin
               sweep_in = ADDR_COLS;
               last_in  = ADDR_LAST;
            end
         end
         tcw_pkg::ST_COPY: begin
            // read runs one row ahead, the write address and enable are registered behind it
            mem_we    = copy_wr_ff;
            mem_waddr = copy_wa_ff;
            mem_wdata = mem_rdata;
         end
         tcw_pkg::ST_FLUSH: begin
            mem_we    = copy_wr_ff;
            mem_waddr = copy_wa_ff;
            mem_wdata = mem_rdata;
            sweep_in  = ADDR_BOT;
            last_in   = ADDR_LAST;
         end
         tcw_pkg::ST_BOTTOM: begin
            mem_we = 1'b1;
         end
         tcw_pkg::ST_POST: begin
            res_valid = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
      res.cell_data       = cell_ff;
      res.cursor_column   = 7'(col_ff);
      res.cursor_row      = 5'(row_ff);
      res.cursor_position = 11'(cur);
      res.scrolled        = scroll_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tcw_pkg::ST_INIT;
         col_ff     <= '0;
         row_ff     <= '0;
         sweep_ff   <= '0;
         last_ff    <= ADDR_LAST;
         scroll_ff  <= 1'b0;
         copy_wr_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         sweep_ff   <= sweep_in;
         last_ff    <= last_in;
         scroll_ff  <= scroll_in;
         copy_wr_ff <= copy_wr_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff    <= cell_in;
      copy_wa_ff <= copy_wa_in;
   end

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < 32'(COLUMNS))
      else $error("cursor column out of range");

   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.scrolled |-> row_ff == ROW_LAST)
      else $error("scroll reported away from the last row");

   a_copy_write: assert property (@(posedge clock) disable iff (reset)
      copy_wr_ff |-> state_ff == tcw_pkg::ST_COPY || state_ff == tcw_pkg::ST_FLUSH)
      else $error("row copy write outside a scroll");

   a_read_path: assert property (@(posedge clock) disable iff (reset)
      accept && is_read |=> state_ff == tcw_pkg::ST_READ || state_ff == tcw_pkg::ST_POST)
      else $error("read item took a store sweep");

endmodule
